// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same check, default clock and reset names of this project
`define ASSERT_STD(label, prop, msg) \
   `ASSERT_CLK(label, clock, reset, prop, msg)

`endif

// ----- rtl/srdf_pkg.sv -----
// ----------------------------------------------------------------------------
// srdf_pkg
// Shared widths, state type and controller command and status types of the
// signed restoring fraction divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srdf_pkg;

   localparam int OPND_BITS       = 32;
   localparam int WHOLE_FIELD_BITS = 32;
   localparam int FRAC_FIELD_BITS = 52;
   localparam int REQ_DATA_BITS   = 64;
   localparam int RSP_DATA_BITS   = 88;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

// ----- rtl/srdf_ctrl.sv -----
// ----------------------------------------------------------------------------
// srdf_ctrl
// Sequencer of the divider: loads operands, counts one quotient bit per
// cycle and hands the result to the output register once it is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srdf_ctrl #(
   parameter int STEPS = 84
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  srdf_pkg::sts_type sts,
   output srdf_pkg::cmd_type cmd
);
   import srdf_pkg::*;

   localparam int CNT_BITS = $clog2(STEPS + 1);

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = CNT_BITS'(STEPS);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cnt_ff != '0) begin
               cmd.step = 1'b1;
               cnt_in   = cnt_ff - 1'b1;
            end else if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- rtl/srdf_datapath.sv -----
// ----------------------------------------------------------------------------
// srdf_datapath
// Operand magnitudes, shared restoring subtractor, quotient shift register
// and the output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srdf_datapath #(
   parameter int WHOLE_BITS    = 32,
   parameter int FRACTION_BITS = 52
) (
   input  logic                                clock,
   input  logic                                reset,
   input  srdf_pkg::cmd_type                   cmd,
   output srdf_pkg::sts_type                   sts,
   input  logic [srdf_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [srdf_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                rsp_tuser
);
   import srdf_pkg::*;

   localparam int STEPS      = WHOLE_BITS + FRACTION_BITS;
   localparam int NUM_SHIFT  = OPND_BITS - WHOLE_BITS;
   localparam int FRAC_SHIFT = FRAC_FIELD_BITS - FRACTION_BITS;

   logic [OPND_BITS-1:0] dividend, divisor, num_mag, den_mag;
   logic [OPND_BITS-1:0] num_ff, num_in, den_ff, den_in, rem_ff, rem_in;
   logic [STEPS-1:0]     q_ff, q_in;
   logic                 zero_ff, zero_in, neg_ff, neg_in;
   logic [OPND_BITS:0]   shifted;
   logic [OPND_BITS+1:0] diff;
   logic                 borrow;

   logic [WHOLE_FIELD_BITS-1:0] whole_val;
   logic [FRAC_FIELD_BITS-1:0]  frac_low, frac_val;
   logic [RSP_DATA_BITS-1:0]    out_ff, out_in;
   logic                        stat_ff, stat_in, valid_ff, valid_in;

   assign dividend = req_tdata[OPND_BITS-1:0];
   assign divisor  = req_tdata[2*OPND_BITS-1:OPND_BITS];
   assign num_mag  = dividend[OPND_BITS-1] ? (~dividend + 1'b1) : dividend;
   assign den_mag  = divisor[OPND_BITS-1]  ? (~divisor + 1'b1)  : divisor;

   // restoring step
   assign shifted = {rem_ff, num_ff[OPND_BITS-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign borrow  = diff[OPND_BITS+1];

   assign whole_val = WHOLE_FIELD_BITS'(q_ff[STEPS-1:FRACTION_BITS]);
   assign frac_low  = FRAC_FIELD_BITS'(q_ff[FRACTION_BITS-1:0]);
   assign frac_val  = frac_low << FRAC_SHIFT;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      zero_in = zero_ff;
      neg_in  = neg_ff;
      if (cmd.load) begin
         num_in  = num_mag << NUM_SHIFT;
         den_in  = den_mag;
         rem_in  = '0;
         q_in    = '0;
         zero_in = (divisor == '0);
         neg_in  = dividend[OPND_BITS-1] ^ divisor[OPND_BITS-1];
      end else if (cmd.step) begin
         num_in = {num_ff[OPND_BITS-2:0], 1'b0};
         rem_in = borrow ? shifted[OPND_BITS-1:0] : diff[OPND_BITS-1:0];
         q_in   = {q_ff[STEPS-2:0], ~borrow};
      end
   end

   always_comb begin
      out_in   = out_ff;
      stat_in  = stat_ff;
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (cmd.finish) begin
         valid_in = 1'b1;
         stat_in  = zero_ff;
         if (zero_ff) begin
            out_in = '0;
         end else begin
            out_in = RSP_DATA_BITS'({neg_ff, frac_val, whole_val});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      zero_ff <= zero_in;
      neg_ff  <= neg_in;
      out_ff  <= out_in;
      stat_ff <= stat_in;
   end

   assign sts.out_free = !valid_ff || rsp_tready;
   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = out_ff;
   assign rsp_tuser    = stat_ff;

endmodule

// ----- rtl/signed_restoring_divider_fraction.sv -----
// ----------------------------------------------------------------------------
// signed_restoring_divider_fraction
// Signed 32-bit divider giving a sign and a fixed-point quotient magnitude.
// ----------------------------------------------------------------------------
// Each request word carries a signed dividend and divisor; the response word
// gives the truncated quotient magnitude with WHOLE_BITS whole and
// FRACTION_BITS fraction bits, plus a negative flag that is the xor of the
// operand signs. A zero divisor returns status 1 with all data zero. One
// shared subtractor forms one quotient bit per cycle. A word is loaded,
// then gets one subtractor step per quotient bit, and then its result is
// written to the output register; only after that is the next request
// accepted. A finished result waits in that register while the next
// request is taken; the divider only stalls at the end of a division if
// the previous result has still not been taken.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module signed_restoring_divider_fraction #(
   parameter int WHOLE_BITS    = 32,
   parameter int FRACTION_BITS = 52
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // dividend [31:0], divisor [63:32]
   input  logic [srdf_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // quotient_whole [31:0], quotient_fraction [83:32], result_negative [84]
   output logic [srdf_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // status [0]
   output logic                                rsp_tuser
);
   import srdf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   srdf_ctrl #(
      .STEPS(WHOLE_BITS + FRACTION_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   srdf_datapath #(
      .WHOLE_BITS    (WHOLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `ASSERT_STD(a_busy_after_accept, (req_tvalid && req_tready) |=> !req_tready, "accept while busy")
   `ASSERT_STD(a_zero_div_data, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0), "divide by zero data")
   `ASSERT_STD(a_result_from_run, $rose(rsp_tvalid) |-> $past(!req_tready), "result without division")

endmodule
